// ===== hw/rtl/bpsa_pkg.sv =====
`default_nettype none
package bpsa_pkg;
  localparam int unsigned MAX_SLOTS_DEF     = 1024;
  localparam int unsigned MAP_WORD_BITS_DEF = 32;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned OSZ_W  = 17;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SIZE_W = 27;
  localparam int unsigned OFF_W  = 26;

  localparam logic [1:0] REG_POOL_BASE = 2'd0;
  localparam logic [1:0] REG_VIRT_BASE = 2'd1;
  localparam logic [1:0] REG_OBJ_SIZE  = 2'd2;
  localparam logic [1:0] REG_SLOT_CNT  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic start;      // latch request, reset scan
    logic rd;         // issue map word read at slot index
    logic scan;       // evaluate one slot of the alloc scan
    logic mark;       // set/clear current slot, write back
    logic div_step;   // one restoring division step
    logic fin;        // load result register
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic range_bad;
    logic scan_end;   // slot index reached count
    logic found;      // bytes covered at this slot
    logic div_done;
    logic mark_done;  // marking reached end of run
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bpsa_ctrl.sv =====
`default_nettype none
module bpsa_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  wire           out_busy_i,
  input  bpsa_pkg::stat_t st_i,
  output bpsa_pkg::cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_DIV, S_RD, S_SCAN, S_MARK, S_DONE
  } state_e;
  state_e state_q, state_d;
  logic back_q, back_d; // scan phase returns to scan after read

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    back_d  = back_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.start = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!st_i.is_free) begin
          back_d = 1'b1;
          state_d = st_i.scan_end ? S_DONE : S_RD;
          cmd_o.rd = 1'b1;
        end else if (st_i.range_bad) state_d = S_DONE;
        else state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_done) begin
          back_d = 1'b0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = back_q ? S_SCAN : S_MARK;
      end
      S_SCAN: begin
        if (st_i.scan_end) state_d = S_DONE;
        else begin
          cmd_o.scan = 1'b1;
          state_d = S_RD;
          if (st_i.found) back_d = 1'b0;
        end
      end
      S_MARK: begin
        if (st_i.mark_done) state_d = S_DONE;
        else begin
          cmd_o.mark = 1'b1;
          state_d = S_RD;
        end
      end
      S_DONE: if (!out_busy_i) begin
        cmd_o.fin = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      back_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      back_q  <= back_d;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bpsa_dp.sv =====
`default_nettype none
module bpsa_dp #(
  parameter int unsigned MAX_SLOTS     = bpsa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAP_WORD_BITS = bpsa_pkg::MAP_WORD_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [1:0]                    cfg_idx_i,
  input  wire [bpsa_pkg::ADDR_W-1:0]   cfg_data_i,
  input  wire                          in_cmd_i,
  input  wire [bpsa_pkg::SIZE_W-1:0]   in_size_i,
  input  wire [bpsa_pkg::ADDR_W-1:0]   in_addr_i,
  input  bpsa_pkg::cmd_t               cmd_i,
  output bpsa_pkg::stat_t              st_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [1:0]                   out_status_o,
  output logic [bpsa_pkg::ADDR_W-1:0]  out_addr_o,
  output logic [bpsa_pkg::OFF_W-1:0]   out_off_o
);
  localparam int unsigned WORDS = (MAX_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WB  = $clog2(MAP_WORD_BITS);
  localparam int unsigned WAW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AW  = bpsa_pkg::ADDR_W;
  localparam int unsigned PW  = SW + bpsa_pkg::OSZ_W;
  localparam int unsigned BW  = bpsa_pkg::SIZE_W + 1;

  logic [AW-1:0] pool_base_q, virt_base_q;
  logic [bpsa_pkg::OSZ_W-1:0] osz_q;
  logic [bpsa_pkg::CNT_W-1:0] cnt_q;
  logic [MAP_WORD_BITS-1:0] map_q [WORDS];
  logic [WORDS-1:0] wvalid_q;
  logic [MAP_WORD_BITS-1:0] rdat_q;
  logic rvalid_q;

  logic [bpsa_pkg::OSZ_W-1:0] osz;
  logic [SW-1:0] cnt;
  assign osz = (osz_q == '0) ? bpsa_pkg::OSZ_W'(1) : osz_q;
  assign cnt = (32'(cnt_q) > MAX_SLOTS) ? SW'(MAX_SLOTS) : SW'(cnt_q);

  logic cmd_q;
  logic [bpsa_pkg::SIZE_W-1:0] size_q;
  logic [AW-1:0] rel_q;
  logic [PW-1:0] pbytes_q;
  logic [SW-1:0] slot_q, start_q, stop_q;
  logic [BW-1:0] bytes_q;
  logic [AW-1:0] rem_q;
  logic [AW-1:0] quo_q;
  logic [5:0] dcnt_q;
  logic below_q;
  logic [AW-1:0] off_q;
  logic found_q;

  logic [BW-1:0] bytes_n;
  logic bit_cur;
  logic [WAW-1:0] widx;
  assign widx = WAW'(slot_q >> WB);
  assign bit_cur = rdat_q[slot_q[WB-1:0]] & rvalid_q;
  assign bytes_n = bytes_q + BW'(osz);

  assign st_o.is_free   = cmd_q;
  assign st_o.range_bad = below_q || ({{(AW-PW){1'b0}}, pbytes_q} <= rel_q) || (cnt == '0);
  assign st_o.scan_end  = (slot_q >= cnt);
  assign st_o.found     = !bit_cur && (bytes_n >= BW'(size_q));
  assign st_o.div_done  = (dcnt_q == 6'd0);
  assign st_o.mark_done = cmd_q ? ((slot_q >= cnt) || (bytes_q >= BW'(size_q) && bytes_q != '0))
                                : (slot_q > stop_q);

  // division remainder step
  logic [AW:0] trial;
  assign trial = {rem_q[AW-2:0], quo_q[AW-1]} - (AW+1)'(osz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      virt_base_q <= '0;
      osz_q <= bpsa_pkg::OSZ_W'(64);
      cnt_q <= bpsa_pkg::CNT_W'(1024);
      wvalid_q <= '0;
      out_valid_o <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bpsa_pkg::REG_POOL_BASE: pool_base_q <= cfg_data_i;
          bpsa_pkg::REG_VIRT_BASE: virt_base_q <= cfg_data_i;
          bpsa_pkg::REG_OBJ_SIZE:  osz_q <= cfg_data_i[bpsa_pkg::OSZ_W-1:0];
          bpsa_pkg::REG_SLOT_CNT:  cnt_q <= cfg_data_i[bpsa_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.fin) out_valid_o <= 1'b1;
      if (cmd_i.mark) wvalid_q[widx] <= 1'b1;
      if (cmd_i.rd) rvalid_q <= wvalid_q[widx];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [MAP_WORD_BITS-1:0] w;
    w = rdat_q;
    if (cmd_i.start) begin
      cmd_q  <= in_cmd_i;
      size_q <= in_size_i;
      rel_q  <= in_addr_i - pool_base_q;
      below_q <= in_addr_i < pool_base_q;
      pbytes_q <= PW'(cnt) * PW'(osz);
      slot_q <= '0;
      start_q <= '0;
      bytes_q <= '0;
      found_q <= 1'b0;
    end
    // read map word at current slot
    if (cmd_i.rd) rdat_q <= map_q[widx];
    if (cmd_i.scan) begin
      if (bit_cur) begin
        bytes_q <= '0;
        slot_q <= slot_q + 1'b1;
        start_q <= slot_q + 1'b1;
      end else if (st_o.found) begin
        found_q <= 1'b1;
        stop_q <= slot_q;
        slot_q <= start_q;
        off_q <= AW'(PW'(start_q) * PW'(osz));
      end else begin
        bytes_q <= bytes_n;
        slot_q <= slot_q + 1'b1;
      end
    end
    if (cmd_i.mark) begin
      w = rvalid_q ? rdat_q : '0;
      w[slot_q[WB-1:0]] = !cmd_q;
      map_q[widx] <= w;
      slot_q <= slot_q + 1'b1;
      if (cmd_q) bytes_q <= bytes_n;
    end
    if (cmd_i.start) begin
      quo_q <= in_addr_i - pool_base_q;
      rem_q <= '0;
      dcnt_q <= 6'(AW);
    end else if (cmd_i.div_step) begin
      if (dcnt_q != 6'd0) begin
        if (!trial[AW]) begin
          rem_q <= trial[AW-1:0];
          quo_q <= {quo_q[AW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[AW-2:0], quo_q[AW-1]};
          quo_q <= {quo_q[AW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 6'd1;
      end else begin
        slot_q <= SW'(quo_q);
      end
    end
    if (cmd_i.fin) begin
      out_addr_o <= '0;
      out_off_o  <= '0;
      if (cmd_q) out_status_o <= st_o.range_bad ? bpsa_pkg::ST_RANGE : bpsa_pkg::ST_OK;
      else if (found_q) begin
        out_status_o <= bpsa_pkg::ST_OK;
        out_addr_o <= virt_base_q + off_q;
        out_off_o <= off_q[bpsa_pkg::OFF_W-1:0];
      end else out_status_o <= bpsa_pkg::ST_NO_SPACE;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_pool_slot_allocator_unit.sv =====
`default_nettype none
// Channel   Dir  Content
// s_axis    in   tdata: cmd[0], size_bytes[27:1], free_address[75:28]
// m_axis    out  tdata: status[1:0], alloc_address[49:2], byte_offset[75:50]
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (no read-back)
// Sequence: accept, then check; allocate then scans slots (read, test) and marks
// each slot of the found run (read, write back); free divides the offset by
// object size (48 steps and a load), then clears each slot (read, write back).
// Each request closes by ending the pass and posting the result.
// The map sits in one single-port word memory; per-word valid flops clear it at reset.
// One request at a time; a result waits in the output register until taken.
module bitmap_pool_slot_allocator_unit #(
  parameter int unsigned MAX_SLOTS     = bpsa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAP_WORD_BITS = bpsa_pkg::MAP_WORD_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire [1:0]   cfg_idx_i,
  input  wire [47:0]  cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [79:0]  s_axis_tdata,  // cmd, size_bytes, free_address
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [79:0] m_axis_tdata   // status, alloc_address, byte_offset
);
  bpsa_pkg::cmd_t  cmd;
  bpsa_pkg::stat_t st;
  logic [1:0] status;
  logic [47:0] addr;
  logic [25:0] off;

  // hold a finished result while it is not taken
  bpsa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_busy_i(m_axis_tvalid && !m_axis_tready),
    .st_i(st), .cmd_o(cmd)
  );
  bpsa_dp #(.MAX_SLOTS(MAX_SLOTS), .MAP_WORD_BITS(MAP_WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_cmd_i(s_axis_tdata[0]), .in_size_i(s_axis_tdata[27:1]),
    .in_addr_i(s_axis_tdata[75:28]),
    .cmd_i(cmd), .st_o(st),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_status_o(status), .out_addr_o(addr), .out_off_o(off)
  );
  assign m_axis_tdata = {4'd0, off, addr, status};

  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> m_axis_tvalid) else $error("result not posted");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !cmd.fin) else $error("result overwritten");
endmodule
`default_nettype wire
